@@ rtl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/caz_pkg.sv @@
`default_nettype none

package caz_pkg;

    // number of cordic iterations per pass, capped at 32
    localparam int CORDIC_STAGES = 24;
    localparam int NUM_ITER      = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

    // field widths
    localparam int COORD_W     = 32;
    localparam int AZ_W        = 25;
    localparam int EL_W        = 24;
    localparam int IN_TDATA_W  = 3 * COORD_W;
    localparam int OUT_RES_W   = AZ_W + EL_W;
    localparam int OUT_TDATA_W = ((OUT_RES_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_RES_W;

    // datapath widths: coordinates carry 16 guard bits, headroom for the gain
    localparam int GUARD_SHIFT = 16;
    localparam int DATA_W      = 52;
    localparam int ANG_W       = 26;

    // gain correction of -z: K in q30, product scaled back by 14 bits
    localparam int GAIN_W     = 32;
    localparam int PROD_W     = COORD_W + 1 + GAIN_W;
    localparam int GAIN_SHIFT = 14;
    localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 32'sd1768195363;

    // angle limits in 1/65536 degree
    localparam logic signed [ANG_W-1:0] AZ_MAX = 26'sd11796480;
    localparam logic signed [ANG_W-1:0] EL_MAX = 26'sd5898240;
    localparam logic signed [ANG_W-1:0] DEG90  = 26'sd5898240;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [ANG_W-1:0]  ang_t;

    // values that ride along the cordic passes
    typedef struct packed {
        logic  az_zero;
        logic  el_zero;
        data_t ey;
        ang_t  az;
    } side_t;

    // one vector in flight
    typedef struct packed {
        data_t x;
        data_t y;
        ang_t  ang;
        side_t side;
    } vec_t;

    // atan(2^-idx) in 1/65536 degree, rounded to nearest
    function automatic ang_t atan_step(input logic [4:0] idx);
        ang_t step;
        unique case (idx)
            5'd0:    step = 26'sd2949120;
            5'd1:    step = 26'sd1740967;
            5'd2:    step = 26'sd919879;
            5'd3:    step = 26'sd466945;
            5'd4:    step = 26'sd234379;
            5'd5:    step = 26'sd117304;
            5'd6:    step = 26'sd58666;
            5'd7:    step = 26'sd29335;
            5'd8:    step = 26'sd14668;
            5'd9:    step = 26'sd7334;
            5'd10:   step = 26'sd3667;
            5'd11:   step = 26'sd1833;
            5'd12:   step = 26'sd917;
            5'd13:   step = 26'sd458;
            5'd14:   step = 26'sd229;
            5'd15:   step = 26'sd115;
            5'd16:   step = 26'sd57;
            5'd17:   step = 26'sd29;
            5'd18:   step = 26'sd14;
            5'd19:   step = 26'sd7;
            5'd20:   step = 26'sd4;
            5'd21:   step = 26'sd2;
            5'd22:   step = 26'sd1;
            default: step = '0;
        endcase
        return step;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cartesian_to_az_el.sv @@
// cartesian_to_az_el: azimuth and elevation of a relative position vector
//
// input request on s_tvalid/s_tready/s_tdata carries pos_x, pos_y, pos_z
// (north, east, down, signed q24.8 metres). each request gives exactly one
// result request on m_tvalid/m_tready/m_tdata: azimuth = atan2(y, x) and
// elevation = atan2(-z, horizontal range), both in 1/65536 degree.
// from accept to m_tvalid a request passes one input stage, two cordic
// vectoring passes of one registered iteration per stage, one output register.
// throughput: one request per cycle unless stalled, one cordic iteration per stage.
// a stalled receiver fills the skid stage behind the output register; the
// whole pipeline then holds and s_tready drops until the skid drains.
// s_tready comes straight from a register.
// reset clears all valid bits and the skid stage; no state survives
// between requests.
`default_nettype none

module cartesian_to_az_el (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [caz_pkg::IN_TDATA_W-1:0]      s_tdata,  // pos_x, pos_y, pos_z
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [caz_pkg::OUT_TDATA_W-1:0]     m_tdata   // azimuth, elevation, zero pad
);
    import caz_pkg::*;

    logic en;
    logic pre_valid;
    vec_t pre_vec;
    logic az_valid;
    vec_t az_vec;
    vec_t el_in;
    logic el_valid;
    vec_t el_vec;

    assign s_tready = en;

    // input stage
    caz_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .pos_x     (s_tdata[COORD_W-1:0]),
        .pos_y     (s_tdata[2*COORD_W-1:COORD_W]),
        .pos_z     (s_tdata[3*COORD_W-1:2*COORD_W]),
        .out_valid (pre_valid),
        .out_vec   (pre_vec)
    );

    // azimuth pass
    caz_vector u_az (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pre_valid),
        .in_vec    (pre_vec),
        .out_valid (az_valid),
        .out_vec   (az_vec)
    );

    // elevation pass starts from (range, gain-scaled -z)
    always_comb
    begin
        el_in         = az_vec;
        el_in.y       = az_vec.side.ey;
        el_in.ang     = '0;
        el_in.side.az = az_vec.ang;
    end

    caz_vector u_el (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (az_valid),
        .in_vec    (el_in),
        .out_valid (el_valid),
        .out_vec   (el_vec)
    );

    // clamp and output buffering
    caz_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (el_valid),
        .in_vec   (el_vec),
        .en       (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

@@ rtl/caz_pre.sv @@
`default_nettype none

module caz_pre (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [caz_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [caz_pkg::COORD_W-1:0]  pos_y,
    input  logic signed [caz_pkg::COORD_W-1:0]  pos_z,
    output logic                                out_valid,
    output caz_pkg::vec_t                       out_vec
);
    import caz_pkg::*;

    logic                      valid_reg;
    vec_t                      vec_reg;
    vec_t                      vec_next;
    data_t                     cx;
    data_t                     cy;
    logic signed [COORD_W:0]   neg_z;
    logic signed [PROD_W-1:0]  prod;

    // guard bits, quadrant pre-rotation and gain-scaled -z
    always_comb
    begin
        cx    = {{(DATA_W-COORD_W-GUARD_SHIFT){pos_x[COORD_W-1]}}, pos_x,
                 {GUARD_SHIFT{1'b0}}};
        cy    = {{(DATA_W-COORD_W-GUARD_SHIFT){pos_y[COORD_W-1]}}, pos_y,
                 {GUARD_SHIFT{1'b0}}};
        neg_z = -{pos_z[COORD_W-1], pos_z};
        prod  = neg_z * GAIN_Q30;

        vec_next.side.az_zero = (pos_x == '0) && (pos_y == '0);
        vec_next.side.el_zero = (pos_x == '0) && (pos_y == '0) && (pos_z == '0);
        vec_next.side.ey      = DATA_W'(prod >>> GAIN_SHIFT);
        vec_next.side.az      = '0;

        if (pos_x[COORD_W-1])
        begin
            if (!pos_y[COORD_W-1])
            begin
                vec_next.x   = cy;
                vec_next.y   = -cx;
                vec_next.ang = DEG90;
            end
            else
            begin
                vec_next.x   = -cy;
                vec_next.y   = cx;
                vec_next.ang = -DEG90;
            end
        end
        else
        begin
            vec_next.x   = cx;
            vec_next.y   = cy;
            vec_next.ang = '0;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
            vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

@@ rtl/caz_vector.sv @@
`default_nettype none

// one cordic vectoring pass, one registered iteration per stage
module caz_vector (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  caz_pkg::vec_t  in_vec,
    output logic           out_valid,
    output caz_pkg::vec_t  out_vec
);
    import caz_pkg::*;

    logic [NUM_ITER-1:0] valid_reg;
    vec_t                vec_reg [NUM_ITER];

    genvar i;
    generate
        for (i = 0; i < NUM_ITER; i++)
        begin : g_stage
            logic  stage_valid;
            vec_t  stage_in;
            vec_t  vec_next;
            data_t dx;
            data_t dy;

            if (i == 0)
            begin : g_head
                assign stage_valid = in_valid;
                assign stage_in    = in_vec;
            end
            else
            begin : g_tail
                assign stage_valid = valid_reg[i-1];
                assign stage_in    = vec_reg[i-1];
            end

            // rotate toward y = 0 and accumulate the angle
            always_comb
            begin
                dx       = stage_in.y >>> i;
                dy       = stage_in.x >>> i;
                vec_next = stage_in;
                if (!stage_in.y[DATA_W-1])
                begin
                    vec_next.x   = stage_in.x + dx;
                    vec_next.y   = stage_in.y - dy;
                    vec_next.ang = stage_in.ang + atan_step(5'(i));
                end
                else
                begin
                    vec_next.x   = stage_in.x - dx;
                    vec_next.y   = stage_in.y + dy;
                    vec_next.ang = stage_in.ang - atan_step(5'(i));
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[i] <= 1'b0;
                else if (en)
                    valid_reg[i] <= stage_valid;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    vec_reg[i] <= vec_next;
            end
        end
    endgenerate

    assign out_valid = valid_reg[NUM_ITER-1];
    assign out_vec   = vec_reg[NUM_ITER-1];

endmodule

`default_nettype wire

@@ rtl/caz_out.sv @@
`default_nettype none

// angle clamping, output register and skid stage
module caz_out (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  caz_pkg::vec_t                       in_vec,
    output logic                                en,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [caz_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import caz_pkg::*;

    logic                    out_valid_reg;
    logic [OUT_TDATA_W-1:0]  out_data_reg;
    logic                    skid_full_reg;
    logic [OUT_TDATA_W-1:0]  skid_data_reg;
    logic [OUT_TDATA_W-1:0]  res_next;
    logic [AZ_W-1:0]         az;
    logic [EL_W-1:0]         el;
    logic                    in_take;

    function automatic ang_t clamp_ang(input ang_t v, input ang_t lim);
        ang_t r;
        if (v > lim)
            r = lim;
        else if (v < -lim)
            r = -lim;
        else
            r = v;
        return r;
    endfunction

    // clamp both angles; zero x and y give zero azimuth, zero vector gives zero elevation
    always_comb
    begin
        az       = in_vec.side.az_zero ? '0 : AZ_W'(clamp_ang(in_vec.side.az, AZ_MAX));
        el       = in_vec.side.el_zero ? '0 : EL_W'(clamp_ang(in_vec.ang, EL_MAX));
        res_next = {{OUT_PAD_W{1'b0}}, el, az};
    end

    // pipeline moves only while the skid stage is empty
    assign en      = !skid_full_reg;
    assign in_take = en && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (m_tready)
                skid_full_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
            out_valid_reg <= in_take;
        else if (in_take)
            skid_full_reg <= 1'b1;
    end

    // result data
    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (m_tready)
                out_data_reg <= skid_data_reg;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (in_take)
                out_data_reg <= res_next;
        end
        else if (in_take)
            skid_data_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/caz_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module caz_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [caz_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import caz_pkg::*;

    logic signed [AZ_W-1:0] az;
    logic signed [EL_W-1:0] el;

    assign az = m_tdata[AZ_W-1:0];
    assign el = m_tdata[OUT_RES_W-1:AZ_W];

    // a stalled result stays put
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // input holds off only behind a waiting result
    `ASSERT_IMPLY(a_stall_cause, clk, rst_n, !s_tready, m_tvalid, "input stalled with no result waiting")

    // azimuth within +-180 degrees
    `ASSERT_IMPLY(a_az_range, clk, rst_n, m_tvalid, (az <= AZ_MAX) && (az >= -AZ_MAX), "azimuth out of range")

    // elevation within +-90 degrees
    `ASSERT_IMPLY(a_el_range, clk, rst_n, m_tvalid, (el <= EL_MAX) && (el >= -EL_MAX), "elevation out of range")

    // padding bits stay zero
    `ASSERT_IMPLY(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[OUT_TDATA_W-1:OUT_RES_W] == '0, "padding bits set")

endmodule

bind cartesian_to_az_el caz_checker u_caz_checker (.*);

`default_nettype wire
